// File: sv/stda_pkg.sv
// ----------------------------------------------------------------------------
// stda_pkg
// Shared payload types, classification flags and constants for the scaled
// time delta accumulator.
// ----------------------------------------------------------------------------
package stda_pkg;

	localparam int unsigned SCALE_IN_FRAC = 16;
	localparam int unsigned SCALE_IN_W    = 17;
	localparam int unsigned DELTA_W       = 31;
	localparam int unsigned QUEUE_DEPTH   = 2;

	typedef struct packed {
		logic signed [31:0]      real_time;
		logic signed [31:0]      real_delta;
		logic signed [31:0]      world_time_now;
		logic [SCALE_IN_W-1:0]   speed_scale;
		logic                    freeze;
	} frame_t;

	typedef struct packed {
		logic [DELTA_W-1:0]      game_delta;
		logic signed [31:0]      game_time_out;
		logic signed [31:0]      visual_time_out;
		logic                    reanchored;
	} result_t;

	typedef struct packed {
		logic frozen;
		logic full_speed;
		logic hi_zero;
		logic delta_pos;
	} cls_t;

endpackage

// File: sv/stda_front.sv
// ----------------------------------------------------------------------------
// stda_front
// Classifies an incoming frame: clamps the speed scale, takes negative deltas
// as zero, extends the timestamps and forms the scaled delta product.
// ----------------------------------------------------------------------------
module stda_front import stda_pkg::*; #(
	parameter int unsigned FRAC_BITS  = 16,
	parameter int unsigned TIME_WIDTH = 32
) (
	input  frame_t                             frame,
	output cls_t                               cls,
	output logic [TIME_WIDTH-1:0]              rtime,
	output logic [TIME_WIDTH-1:0]              world,
	output logic [DELTA_W-1:0]                 rdelta,
	output logic [DELTA_W+FRAC_BITS-1:0]       prod
);

	localparam int unsigned EXT_W  = FRAC_BITS + SCALE_IN_W;
	localparam int unsigned PROD_W = DELTA_W + FRAC_BITS;
	localparam logic [EXT_W-1:0] SCALE_ONE = EXT_W'(1) << FRAC_BITS;
	localparam logic [FRAC_BITS:0] SCALE_MIN =
		(FRAC_BITS+1)'(((65'd1 << FRAC_BITS) + 65'd10) / 65'd20);

	logic [EXT_W-1:0]        scale_ext;
	logic [FRAC_BITS-1:0]    scale_frac;
	logic [TIME_WIDTH+31:0]  rtime_sx;
	logic [TIME_WIDTH+31:0]  world_sx;

	always_comb begin
		scale_ext = (EXT_W'(frame.speed_scale) << FRAC_BITS) >> SCALE_IN_FRAC;
		if (scale_ext < EXT_W'(SCALE_MIN)) begin
			scale_frac = SCALE_MIN[FRAC_BITS-1:0];
		end else begin
			scale_frac = scale_ext[FRAC_BITS-1:0];
		end
	end

	assign rtime_sx = {{TIME_WIDTH{frame.real_time[31]}}, frame.real_time};
	assign world_sx = {{TIME_WIDTH{frame.world_time_now[31]}}, frame.world_time_now};
	assign rtime    = rtime_sx[TIME_WIDTH-1:0];
	assign world    = world_sx[TIME_WIDTH-1:0];
	assign rdelta   = frame.real_delta[31] ? '0 : frame.real_delta[DELTA_W-1:0];
	assign prod     = PROD_W'(rdelta) * PROD_W'(scale_frac);

	assign cls.frozen     = frame.freeze;
	assign cls.full_speed = (frame.speed_scale == '0) || (scale_ext >= SCALE_ONE);
	assign cls.hi_zero    = (prod[PROD_W-1:FRAC_BITS] == '0);
	assign cls.delta_pos  = (rdelta != '0);

endmodule

// File: sv/stda_fifo.sv
// ----------------------------------------------------------------------------
// stda_fifo
// Short register queue that decouples frame classification from the
// accumulator so that each side can stall on its own.
// ----------------------------------------------------------------------------
module stda_fifo #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 2
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] wdata,
	output logic             full,
	input  logic             pop,
	output logic             not_empty,
	output logic [WIDTH-1:0] rdata
);

	localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [AW-1:0]    wptr_q;
	logic [AW-1:0]    rptr_q;
	logic [AW:0]      count_q;
	logic             do_push;
	logic             do_pop;

	assign full      = (count_q == (AW+1)'(DEPTH));
	assign not_empty = (count_q != '0);
	assign do_push   = push && !full;
	assign do_pop    = pop && not_empty;
	assign rdata     = mem_q[rptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= '0;
			rptr_q  <= '0;
			count_q <= '0;
		end else begin
			if (do_push) begin
				wptr_q <= (wptr_q == AW'(DEPTH-1)) ? '0 : wptr_q + 1'b1;
			end
			if (do_pop) begin
				rptr_q <= (rptr_q == AW'(DEPTH-1)) ? '0 : rptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// File: sv/stda_back.sv
// ----------------------------------------------------------------------------
// stda_back
// Keeps game time, visual time and the fractional remainder, applies one
// classified frame per cycle unless a held result is not yet taken, and holds the result in an output register.
// ----------------------------------------------------------------------------
module stda_back import stda_pkg::*; #(
	parameter int unsigned FRAC_BITS  = 16,
	parameter int unsigned TIME_WIDTH = 32
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          entry_valid,
	output logic                          entry_pop,
	input  cls_t                          cls,
	input  logic [TIME_WIDTH-1:0]         rtime,
	input  logic [TIME_WIDTH-1:0]         world,
	input  logic [DELTA_W-1:0]            rdelta,
	input  logic [DELTA_W+FRAC_BITS-1:0]  prod,
	output logic                          result_valid,
	input  logic                          result_ready,
	output result_t                       result
);

	localparam int unsigned PROD_W = DELTA_W + FRAC_BITS;

	logic                    running_q;
	logic [TIME_WIDTH-1:0]   game_time_q;
	logic [TIME_WIDTH-1:0]   visual_time_q;
	logic [FRAC_BITS-1:0]    frac_q;
	logic                    out_valid_q;
	result_t                 out_q;

	logic                    reanchor;
	logic [FRAC_BITS-1:0]    frac_base;
	logic [FRAC_BITS:0]      sum_lo;
	logic [DELTA_W-1:0]      gdelta;
	logic [FRAC_BITS-1:0]    frac_n;
	logic [TIME_WIDTH-1:0]   game_base;
	logic [TIME_WIDTH-1:0]   game_n;
	logic [TIME_WIDTH-1:0]   visual_n;
	logic [TIME_WIDTH+31:0]  game_zx;
	logic [TIME_WIDTH+31:0]  visual_zx;

	assign entry_pop = entry_valid && (!out_valid_q || result_ready);

	always_comb begin
		reanchor  = !running_q || (world != game_time_q);
		frac_base = reanchor ? '0 : frac_q;
		sum_lo    = {1'b0, prod[FRAC_BITS-1:0]} + {1'b0, frac_base};
		if (cls.frozen) begin
			gdelta = '0;
			frac_n = '0;
		end else if (cls.full_speed) begin
			gdelta = rdelta;
			frac_n = '0;
		end else if (cls.hi_zero && !sum_lo[FRAC_BITS] && cls.delta_pos) begin
			gdelta = DELTA_W'(1);
			frac_n = '0;
		end else begin
			gdelta = prod[PROD_W-1:FRAC_BITS] + DELTA_W'(sum_lo[FRAC_BITS]);
			frac_n = sum_lo[FRAC_BITS-1:0];
		end
		game_base = reanchor ? world : game_time_q;
		game_n    = game_base + TIME_WIDTH'(gdelta);
		visual_n  = reanchor ? rtime : visual_time_q + TIME_WIDTH'(gdelta);
		game_zx   = {32'b0, game_n};
		visual_zx = {32'b0, visual_n};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			running_q     <= 1'b0;
			game_time_q   <= '0;
			visual_time_q <= '0;
			frac_q        <= '0;
			out_valid_q   <= 1'b0;
		end else begin
			if (entry_pop) begin
				running_q     <= 1'b1;
				game_time_q   <= game_n;
				visual_time_q <= visual_n;
				frac_q        <= frac_n;
				out_valid_q   <= 1'b1;
			end else if (result_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (entry_pop) begin
			out_q.game_delta      <= gdelta;
			out_q.game_time_out   <= game_zx[31:0];
			out_q.visual_time_out <= visual_zx[31:0];
			out_q.reanchored      <= reanchor;
		end
	end

	assign result_valid = out_valid_q;
	assign result       = out_q;

endmodule

// File: sv/scaled_time_delta_accumulator.sv
// ----------------------------------------------------------------------------
// scaled_time_delta_accumulator
// Advances game and visual time by a speed-scaled frame delta, carrying the
// fractional remainder between frames and re-anchoring to world time.
// ----------------------------------------------------------------------------
// The block takes one frame per clock cycle while its queue is not full and
// returns one result per frame, in order. A frame is written into the queue,
// and its result is loaded from there into the output register once the back
// end is free to take it. The front end clamps the scale and forms the
// scaled product; a two-entry queue feeds the back end, whose update of
// remainder and game time sets the rate, so frames keep arriving while a
// result waits to be taken until the queue fills.
module scaled_time_delta_accumulator import stda_pkg::*; #(
	parameter int unsigned FRAC_BITS  = 16,
	parameter int unsigned TIME_WIDTH = 32
) (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    frame_valid,
	output logic    frame_ready,
	input  frame_t  frame,
	output logic    result_valid,
	input  logic    result_ready,
	output result_t result
);

	localparam int unsigned PROD_W  = DELTA_W + FRAC_BITS;
	localparam int unsigned ENTRY_W = $bits(cls_t) + 2 * TIME_WIDTH + DELTA_W + PROD_W;

	cls_t                   f_cls;
	logic [TIME_WIDTH-1:0]  f_rtime;
	logic [TIME_WIDTH-1:0]  f_world;
	logic [DELTA_W-1:0]     f_rdelta;
	logic [PROD_W-1:0]      f_prod;

	cls_t                   b_cls;
	logic [TIME_WIDTH-1:0]  b_rtime;
	logic [TIME_WIDTH-1:0]  b_world;
	logic [DELTA_W-1:0]     b_rdelta;
	logic [PROD_W-1:0]      b_prod;

	logic [ENTRY_W-1:0]     q_wdata;
	logic [ENTRY_W-1:0]     q_rdata;
	logic                   q_full;
	logic                   q_not_empty;
	logic                   q_pop;

	stda_front #(
		.FRAC_BITS  (FRAC_BITS),
		.TIME_WIDTH (TIME_WIDTH)
	) u_front (
		.frame  (frame),
		.cls    (f_cls),
		.rtime  (f_rtime),
		.world  (f_world),
		.rdelta (f_rdelta),
		.prod   (f_prod)
	);

	assign q_wdata     = {f_cls, f_rtime, f_world, f_rdelta, f_prod};
	assign frame_ready = !q_full;

	stda_fifo #(
		.WIDTH (ENTRY_W),
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (frame_valid),
		.wdata     (q_wdata),
		.full      (q_full),
		.pop       (q_pop),
		.not_empty (q_not_empty),
		.rdata     (q_rdata)
	);

	assign {b_cls, b_rtime, b_world, b_rdelta, b_prod} = q_rdata;

	stda_back #(
		.FRAC_BITS  (FRAC_BITS),
		.TIME_WIDTH (TIME_WIDTH)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.entry_valid  (q_not_empty),
		.entry_pop    (q_pop),
		.cls          (b_cls),
		.rtime        (b_rtime),
		.world        (b_world),
		.rdelta       (b_rdelta),
		.prod         (b_prod),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result)
	);

endmodule
